// File: rtl/core/pfa_pkg.sv
// Page frame allocator package: sizes, operation and status codes, item types.
// Shared by the controller, the datapath and the top level; no dependencies.
package pfa_pkg;

  // Frame space and counter sizes
  localparam int FRAMES          = 1024;
  localparam int RESERVED_FRAMES = 256;
  localparam int FRAME_W         = 10;
  localparam int FCNT_W          = 11;
  localparam int CNT_W           = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [FCNT_W-1:0] FCNT_INIT = FCNT_W'(FRAMES - RESERVED_FRAMES);
  localparam logic [FCNT_W-1:0] FRAMES_C  = FCNT_W'(FRAMES);
  localparam logic [FCNT_W-1:0] RES_C     = FCNT_W'(RESERVED_FRAMES);
  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAMES - 1);

  // Operation codes
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_DROP  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_COUNT = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [FRAME_W-1:0] frame;
  } pfa_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] result_frame;
    logic [1:0]         status;
    logic               freed;
    logic [CNT_W-1:0]   count_after;
  } pfa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic init_we;
    logic accept;
    logic exec;
  } pfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic init_last;
  } pfa_sts_t;

endpackage

// File: rtl/core/page_frame_allocator_refcount_top.sv
// Page frame allocator with reference counts: top level.
// The item and its memory reads are registered on acceptance, and the execute state
// then loads the result register and strobe. A new item is accepted only once the
// read-modify-write of the count and stack memories is done. Reset (synchronous,
// rst_n low) sweeps both memories to load them; busy stays high until it ends.
// Results cannot be stalled. Depends on pfa_pkg, pfa_ctrl and pfa_dpath.
module page_frame_allocator_refcount_top
  import pfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pfa_in_t  in_item,
  output logic     out_valid,
  output pfa_out_t out_item
);

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  pfa_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/pfa_ctrl.sv
// Page frame allocator controller: initialisation sweep, idle and execute states.
// Depends on pfa_pkg.
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  pfa_sts_t sts,
  output logic     busy,
  output pfa_cmd_t cmd
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.init_we = 1'b0;
    cmd.accept  = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_we = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/core/pfa_dpath.sv
// Page frame allocator datapath: count and free-stack memories, stack depth,
// read-modify-write logic and the result register. Depends on pfa_pkg.
module pfa_dpath
  import pfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  pfa_cmd_t cmd,
  input  pfa_in_t  in_item,
  output pfa_sts_t sts,
  output logic     out_valid,
  output pfa_out_t out_item
);

  logic [CNT_W-1:0]   cnt_mem [FRAMES];
  logic [FRAME_W-1:0] stk_mem [FRAMES];

  logic [FCNT_W-1:0]  free_count_r, free_count_nxt;
  logic [FRAME_W-1:0] init_addr_r;
  logic [1:0]         func_r;
  logic [FRAME_W-1:0] frame_r;
  logic [CNT_W-1:0]   cnt_rd_r;
  logic [FRAME_W-1:0] stk_rd_r;
  logic               out_valid_r;
  pfa_out_t           out_r, res;

  logic               cnt_we, stk_we;
  logic [FRAME_W-1:0] cnt_waddr, stk_waddr, stk_wdata, pop_frame;
  logic [CNT_W-1:0]   cnt_wdata, cnt_dec;
  logic               in_range;

  assign sts.init_last = (init_addr_r == LAST_FRAME);

  // Sweep counter for the memory initialisation after reset
  always_ff @(posedge clk) begin
    if (!rst_n)           init_addr_r <= '0;
    else if (cmd.init_we) init_addr_r <= init_addr_r + 1'b1;
  end

  // Latch the item and read both memories at the top of the stack / frame
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_item.func;
      frame_r  <= in_item.frame;
      cnt_rd_r <= cnt_mem[in_item.frame];
      stk_rd_r <= stk_mem[FRAME_W'(free_count_r - 1'b1)];
    end
  end

  assign in_range  = (FCNT_W'(frame_r) < FRAMES_C);
  assign cnt_dec   = cnt_rd_r - 1'b1;
  assign pop_frame = (FCNT_W'(stk_rd_r) < FRAMES_C) ? stk_rd_r : '0;

  // Execute: decide the result and the memory updates
  always_comb begin
    res            = '{result_frame: frame_r, status: ST_RANGE, freed: 1'b0,
                       count_after: '0};
    free_count_nxt = free_count_r;
    cnt_we         = 1'b0;
    cnt_waddr      = frame_r;
    cnt_wdata      = cnt_rd_r;
    stk_we         = 1'b0;
    stk_waddr      = FRAME_W'(free_count_r);
    stk_wdata      = frame_r;
    if (cmd.init_we) begin
      cnt_we    = 1'b1;
      cnt_waddr = init_addr_r;
      cnt_wdata = (FCNT_W'(init_addr_r) < RES_C) ? CNT_W'(1) : '0;
      stk_we    = 1'b1;
      stk_waddr = init_addr_r;
      stk_wdata = FRAME_W'(FCNT_W'(init_addr_r) + RES_C);
    end else if (cmd.exec) begin
      case (func_r)
        FN_ALLOC: begin
          if (free_count_r == '0) begin
            res = '{result_frame: '0, status: ST_EMPTY, freed: 1'b0, count_after: '0};
          end else begin
            free_count_nxt = free_count_r - 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = pop_frame;
            cnt_wdata = CNT_W'(1);
            res = '{result_frame: pop_frame, status: ST_OK, freed: 1'b0,
                    count_after: CNT_W'(1)};
          end
        end
        FN_ADD: begin
          if (in_range) begin
            if (cnt_rd_r == '0 || cnt_rd_r == CNT_MAX) begin
              res = '{result_frame: frame_r, status: ST_COUNT, freed: 1'b0,
                      count_after: cnt_rd_r};
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rd_r + 1'b1;
              res = '{result_frame: frame_r, status: ST_OK, freed: 1'b0,
                      count_after: cnt_rd_r + 1'b1};
            end
          end
        end
        FN_DROP: begin
          if (in_range) begin
            if (cnt_rd_r == '0) begin
              res = '{result_frame: frame_r, status: ST_COUNT, freed: 1'b0,
                      count_after: '0};
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_dec;
              if (cnt_dec == '0) begin
                // last reference gone: frame goes back on the stack unless it is full
                if (free_count_r < FRAMES_C) begin
                  stk_we         = 1'b1;
                  free_count_nxt = free_count_r + 1'b1;
                end
                res = '{result_frame: frame_r, status: ST_OK, freed: 1'b1,
                        count_after: '0};
              end else begin
                res = '{result_frame: frame_r, status: ST_OK, freed: 1'b0,
                        count_after: cnt_dec};
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
  end

  // Stack depth and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r <= FCNT_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      free_count_r <= free_count_nxt;
      out_valid_r  <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
